// ===== hdl/dlds_pkg.sv =====
// ----------------------------------------------------------------------------
// dlds_pkg
// Shared types, widths and the dot pattern ROM of the dot serializer.
// ----------------------------------------------------------------------------
package dlds_pkg;

    localparam int COLUMNS_DEFAULT = 40;
    localparam int QUEUE_DEPTH     = 2;

    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int PAT_W   = 7;
    localparam int DOTS_W  = 24;
    localparam int CNT_W   = 5;
    localparam int INDEX_W = 4;

    // 7-dot patterns; the upper half is the rotated set for odd columns
    localparam logic [PAT_W-1:0] DOT_ROM [0:31] = '{
        7'h00, 7'h11, 7'h22, 7'h33, 7'h44, 7'h55, 7'h66, 7'h77,
        7'h08, 7'h19, 7'h2A, 7'h3B, 7'h4C, 7'h5D, 7'h6E, 7'h7F,
        7'h00, 7'h44, 7'h08, 7'h4C, 7'h11, 7'h55, 7'h19, 7'h5D,
        7'h22, 7'h66, 7'h2A, 7'h6E, 7'h33, 7'h77, 7'h3B, 7'h7F
    };

    // one classified column waiting for the back end
    typedef struct packed {
        logic [PAT_W-1:0] up_aux;
        logic [PAT_W-1:0] up_main;
        logic [PAT_W-1:0] lo_aux;
        logic [PAT_W-1:0] lo_main;
        logic             first;
        logic             last;
        logic             mono;
    } dlds_item_t;

endpackage

// ===== hdl/dlds_front.sv =====
// ----------------------------------------------------------------------------
// dlds_front
// Takes column beats, tracks the column position, holds the mode register
// and looks up the dot patterns for both cell rows.
// ----------------------------------------------------------------------------
module dlds_front import dlds_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_mono_enable,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_aux_byte,
    input  logic [BYTE_W-1:0] s_main_byte,
    input  logic              q_full,
    output logic              q_push,
    output dlds_item_t        q_item
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic             mono_reg;
    logic             col_last;
    logic             rot;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready;

    assign col_last = (col_reg >= LAST_COL);
    assign rot      = col_reg[0];
    assign col_next = col_last ? '0 : col_reg + 1'b1;

    always_comb begin
        q_item.up_aux  = DOT_ROM[{rot, s_aux_byte[NIB_W-1:0]}];
        q_item.lo_aux  = DOT_ROM[{rot, s_aux_byte[BYTE_W-1:NIB_W]}];
        q_item.up_main = DOT_ROM[{rot, s_main_byte[NIB_W-1:0]}];
        q_item.lo_main = DOT_ROM[{rot, s_main_byte[BYTE_W-1:NIB_W]}];
        q_item.first   = (col_reg == '0);
        q_item.last    = col_last;
        q_item.mono    = mono_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            mono_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mono_reg <= cfg_mono_enable;
            end
            if (q_push) begin
                col_reg <= col_next;
            end
        end
    end

endmodule

// ===== hdl/dlds_queue.sv =====
// ----------------------------------------------------------------------------
// dlds_queue
// Small FIFO of classified columns between the front and back ends.
// ----------------------------------------------------------------------------
module dlds_queue import dlds_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  dlds_item_t push_item,
    output logic       full,
    output logic       valid,
    output dlds_item_t head,
    input  logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    dlds_item_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/dlds_back.sv =====
// ----------------------------------------------------------------------------
// dlds_back
// Dot shift registers for both cell rows and the word sequencer; emits one
// result beat per cycle into the output register while a column is held and m_ready does not stall it.
// ----------------------------------------------------------------------------
module dlds_back import dlds_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  dlds_item_t         q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_upper_first_index,
    output logic [INDEX_W-1:0] m_upper_second_index,
    output logic [INDEX_W-1:0] m_lower_first_index,
    output logic [INDEX_W-1:0] m_lower_second_index,
    output logic               m_run_last,
    output logic               m_line_end
);

    typedef enum logic [2:0] {
        W_FIRST,
        W_PAIR_A,
        W_PAIR_B,
        W_LAST,
        W_MONO
    } word_kind_t;

    logic [DOTS_W-1:0]  up_reg, lo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               first_reg;   // color lead-in word pending
    logic               lastw_reg;   // color line-end word pending
    logic               last_reg;
    logic               mono_reg;
    logic               phase_reg;   // second word of a color pair
    logic [2:0]         mono_n_reg;

    logic               m_valid_reg, m_run_last_reg, m_line_end_reg;
    logic [INDEX_W-1:0] m_uf_reg, m_us_reg, m_lf_reg, m_ls_reg;

    word_kind_t         kind;
    logic               advance, done, load;
    logic [INDEX_W-1:0] w_uf, w_us, w_lf, w_ls;
    logic [DOTS_W-1:0]  up_aft, lo_aft;
    logic [CNT_W-1:0]   cnt_aft;
    logic [DOTS_W-1:0]  base_up, base_lo, up_new, lo_new;
    logic [2:0]         base_cnt;
    logic [3:0]         main_sh;

    assign advance = busy_reg && (!m_valid_reg || m_ready);

    always_comb begin
        if (mono_reg) begin
            kind = W_MONO;
        end else if (first_reg) begin
            kind = W_FIRST;
        end else if (phase_reg) begin
            kind = W_PAIR_B;
        end else if (cnt_reg >= CNT_W'(8)) begin
            kind = W_PAIR_A;
        end else begin
            kind = W_LAST;
        end
    end

    always_comb begin
        w_uf    = up_reg[3:0];
        w_us    = up_reg[3:0];
        w_lf    = lo_reg[3:0];
        w_ls    = lo_reg[3:0];
        up_aft  = up_reg;
        lo_aft  = lo_reg;
        cnt_aft = cnt_reg;
        done    = 1'b0;
        case (kind)
            W_MONO: begin
                w_uf    = {3'b000, up_reg[0]};
                w_us    = {3'b000, up_reg[1]};
                w_lf    = {3'b000, lo_reg[0]};
                w_ls    = {3'b000, lo_reg[1]};
                up_aft  = up_reg >> 2;
                lo_aft  = lo_reg >> 2;
                cnt_aft = cnt_reg - CNT_W'(2);
                done    = (mono_n_reg == 3'd6) || (cnt_reg < CNT_W'(4));
            end
            W_FIRST: begin
                w_uf = '0;
                w_lf = '0;
                done = !((cnt_reg >= CNT_W'(8)) || lastw_reg);
            end
            W_PAIR_A: begin
                done = 1'b0;
            end
            W_PAIR_B: begin
                w_uf    = {up_reg[3:2], up_reg[5:4]};
                w_us    = up_reg[7:4];
                w_lf    = {lo_reg[3:2], lo_reg[5:4]};
                w_ls    = lo_reg[7:4];
                up_aft  = up_reg >> 4;
                lo_aft  = lo_reg >> 4;
                cnt_aft = cnt_reg - CNT_W'(4);
                done    = (cnt_reg < CNT_W'(12)) && !lastw_reg;
            end
            W_LAST: begin
                done = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
        if (!advance) begin
            up_aft  = up_reg;
            lo_aft  = lo_reg;
            cnt_aft = cnt_reg;
        end
    end

    // next column merges into what is left after this cycle's word
    assign load     = q_valid && (!busy_reg || (advance && done));
    assign q_pop    = load;
    assign base_up  = q_item.first ? '0 : up_aft;
    assign base_lo  = q_item.first ? '0 : lo_aft;
    assign base_cnt = q_item.first ? 3'd0 : cnt_aft[2:0];
    assign main_sh  = {1'b0, base_cnt} + 4'd7;

    always_comb begin
        up_new = base_up
               | ({{(DOTS_W-PAT_W){1'b0}}, q_item.up_aux} << base_cnt)
               | ({{(DOTS_W-PAT_W){1'b0}}, q_item.up_main} << main_sh);
        lo_new = base_lo
               | ({{(DOTS_W-PAT_W){1'b0}}, q_item.lo_aux} << base_cnt)
               | ({{(DOTS_W-PAT_W){1'b0}}, q_item.lo_main} << main_sh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg      <= '0;
            lo_reg      <= '0;
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            first_reg   <= 1'b0;
            lastw_reg   <= 1'b0;
            last_reg    <= 1'b0;
            mono_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            mono_n_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg    <= 1'b1;
                m_uf_reg       <= w_uf;
                m_us_reg       <= w_us;
                m_lf_reg       <= w_lf;
                m_ls_reg       <= w_ls;
                m_run_last_reg <= done;
                m_line_end_reg <= done && last_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (load) begin
                busy_reg   <= 1'b1;
                up_reg     <= up_new;
                lo_reg     <= lo_new;
                cnt_reg    <= {2'b00, base_cnt} + CNT_W'(14);
                first_reg  <= !q_item.mono && q_item.first;
                lastw_reg  <= !q_item.mono && q_item.last;
                last_reg   <= q_item.last;
                mono_reg   <= q_item.mono;
                phase_reg  <= 1'b0;
                mono_n_reg <= '0;
            end else if (advance) begin
                up_reg  <= up_aft;
                lo_reg  <= lo_aft;
                cnt_reg <= cnt_aft;
                case (kind)
                    W_MONO:   mono_n_reg <= mono_n_reg + 3'd1;
                    W_FIRST:  first_reg <= 1'b0;
                    W_PAIR_A: phase_reg <= 1'b1;
                    W_PAIR_B: phase_reg <= 1'b0;
                    W_LAST:   lastw_reg <= 1'b0;
                    default:  phase_reg <= 1'b0;
                endcase
                if (done) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_upper_first_index  = m_uf_reg;
    assign m_upper_second_index = m_us_reg;
    assign m_lower_first_index  = m_lf_reg;
    assign m_lower_second_index = m_ls_reg;
    assign m_run_last           = m_run_last_reg;
    assign m_line_end           = m_line_end_reg;

endmodule

// ===== hdl/double_lores_dot_serializer_unit.sv =====
// a column beat is written into the queue, then loaded into the back-end dot
// registers, and its first word is then registered in the output register
// throughput: one result word per cycle unless m_ready stalls the output; a column
// yields 4 to 9 words in color mode and 7 in mono mode
// reset: aresetn is synchronous, active low; it clears the column position,
// mode register, dot registers, queue and output valid
// ----------------------------------------------------------------------------
// double_lores_dot_serializer_unit
// Top level: turns double low-res screen columns into pixel index words.
// ----------------------------------------------------------------------------
module double_lores_dot_serializer_unit import dlds_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_mono_enable,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_aux_byte,
    input  logic [BYTE_W-1:0]  s_main_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_upper_first_index,
    output logic [INDEX_W-1:0] m_upper_second_index,
    output logic [INDEX_W-1:0] m_lower_first_index,
    output logic [INDEX_W-1:0] m_lower_second_index,
    output logic               m_run_last,
    output logic               m_line_end
);

    logic       q_push, q_full, q_valid, q_pop;
    dlds_item_t push_item, head_item;

    dlds_front #(
        .COLUMNS(COLUMNS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_mono_enable (cfg_mono_enable),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_aux_byte      (s_aux_byte),
        .s_main_byte     (s_main_byte),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (push_item)
    );

    dlds_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .valid     (q_valid),
        .head      (head_item),
        .pop       (q_pop)
    );

    dlds_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .q_valid              (q_valid),
        .q_item               (head_item),
        .q_pop                (q_pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_upper_first_index  (m_upper_first_index),
        .m_upper_second_index (m_upper_second_index),
        .m_lower_first_index  (m_lower_first_index),
        .m_lower_second_index (m_lower_second_index),
        .m_run_last           (m_run_last),
        .m_line_end           (m_line_end)
    );

endmodule

// ===== hdl/dlds_checker.sv =====
// ----------------------------------------------------------------------------
// dlds_checker
// Port-level checks on the dot serializer, bound to the top level.
// ----------------------------------------------------------------------------
module dlds_checker import dlds_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [INDEX_W-1:0] m_upper_first_index,
    input logic [INDEX_W-1:0] m_upper_second_index,
    input logic [INDEX_W-1:0] m_lower_first_index,
    input logic [INDEX_W-1:0] m_lower_second_index,
    input logic               m_run_last,
    input logic               m_line_end
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_upper_first_index)
            && $stable(m_upper_second_index) && $stable(m_lower_first_index)
            && $stable(m_lower_second_index) && $stable(m_run_last)
            && $stable(m_line_end))
        else $error("result beat changed while stalled");

    // the end of a line is also the end of its column
    a_line_end_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_end |-> m_run_last)
        else $error("line_end without run_last");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind double_lores_dot_serializer_unit dlds_checker u_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_upper_first_index  (m_upper_first_index),
    .m_upper_second_index (m_upper_second_index),
    .m_lower_first_index  (m_lower_first_index),
    .m_lower_second_index (m_lower_second_index),
    .m_run_last           (m_run_last),
    .m_line_end           (m_line_end)
);

// ===== sim/tb_double_lores_dot_serializer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_lores_dot_serializer_unit
// Feeds screen columns to the double low-res dot serializer with random
// gaps and stalls on both channels. Every pixel word is checked against a
// software copy of the dot shift registers. The run covers color and mono
// mode, line starts and ends, and mode changes in the middle of a line.
// ----------------------------------------------------------------------------
module tb_double_lores_dot_serializer_unit;
    import dlds_pkg::*;

    localparam int LINE_COLUMNS = 40;
    localparam int IDLE_LIMIT   = 2000;

    // 7-dot pattern per nibble; the second half is used on odd columns
    localparam logic [6:0] DOT_PATTERN [32] = '{
        7'h00, 7'h11, 7'h22, 7'h33, 7'h44, 7'h55, 7'h66, 7'h77,
        7'h08, 7'h19, 7'h2A, 7'h3B, 7'h4C, 7'h5D, 7'h6E, 7'h7F,
        7'h00, 7'h44, 7'h08, 7'h4C, 7'h11, 7'h55, 7'h19, 7'h5D,
        7'h22, 7'h66, 7'h2A, 7'h6E, 7'h33, 7'h77, 7'h3B, 7'h7F
    };

    typedef struct packed {
        logic [INDEX_W-1:0] upper_first;
        logic [INDEX_W-1:0] upper_second;
        logic [INDEX_W-1:0] lower_first;
        logic [INDEX_W-1:0] lower_second;
        logic               run_last;
        logic               line_end;
    } pixel_word_t;

    class dot_word_scoreboard;
        bit          mono;
        logic [31:0] upper_dots;
        logic [31:0] lower_dots;
        int unsigned dot_count;
        int unsigned column;
        int unsigned line_columns;
        int          errors;
        pixel_word_t pending_words[$];

        function new(int unsigned columns);
            line_columns = columns;
            mono         = 1'b0;
            upper_dots   = '0;
            lower_dots   = '0;
            dot_count    = 0;
            column       = 0;
            errors       = 0;
        endfunction

        function void push_word(logic [31:0] uf, logic [31:0] us,
                                logic [31:0] lf, logic [31:0] ls);
            pixel_word_t w;
            w.upper_first  = uf[3:0];
            w.upper_second = us[3:0];
            w.lower_first  = lf[3:0];
            w.lower_second = ls[3:0];
            w.run_last     = 1'b0;
            w.line_end     = 1'b0;
            pending_words.push_back(w);
        endfunction

        // works out every word that one accepted column beat produces
        function void note_column(logic [7:0] aux, logic [7:0] mainb);
            logic [31:0] up;
            logic [31:0] lo;
            int unsigned base;
            int unsigned n;
            bit          first_col;
            bit          last_col;
            first_col = (column == 0);
            if (first_col) begin
                upper_dots = '0;
                lower_dots = '0;
                dot_count  = 0;
            end
            dot_count = dot_count & 7;
            base = (column & 1) << 4;
            up = upper_dots;
            lo = lower_dots;
            up |= 32'(DOT_PATTERN[base | aux[3:0]]) << dot_count;
            lo |= 32'(DOT_PATTERN[base | aux[7:4]]) << dot_count;
            dot_count += 7;
            up |= 32'(DOT_PATTERN[base | mainb[3:0]]) << dot_count;
            lo |= 32'(DOT_PATTERN[base | mainb[7:4]]) << dot_count;
            dot_count += 7;
            up &= 32'h00ff_ffff;
            lo &= 32'h00ff_ffff;
            last_col = (column >= line_columns - 1);
            column = last_col ? 0 : column + 1;
            n = 0;
            if (mono) begin
                while (n < 7 && dot_count >= 2) begin
                    push_word(up & 1, (up >> 1) & 1, lo & 1, (lo >> 1) & 1);
                    up >>= 2;
                    lo >>= 2;
                    dot_count -= 2;
                    n++;
                end
            end else begin
                if (first_col) begin
                    push_word(0, up, 0, lo);
                    n++;
                end
                while (dot_count >= 8) begin
                    push_word(up, up, lo, lo);
                    // second word carries the half-bright pixel
                    push_word((up & 32'hc) | ((up & 32'h30) >> 4), (up & 32'hf0) >> 4,
                              (lo & 32'hc) | ((lo & 32'h30) >> 4), (lo & 32'hf0) >> 4);
                    up >>= 4;
                    lo >>= 4;
                    dot_count -= 4;
                    n += 2;
                end
                if (last_col) begin
                    push_word(up, up, lo, lo);
                    n++;
                end
            end
            upper_dots = up;
            lower_dots = lo;
            if (n > 0) begin
                pending_words[pending_words.size() - 1].run_last = 1'b1;
                if (last_col)
                    pending_words[pending_words.size() - 1].line_end = 1'b1;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_field(string name, logic [3:0] got, logic [3:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        endtask

        task check_word(pixel_word_t got);
            pixel_word_t want;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("word %h with no column pending", got));
                return;
            end
            want = pending_words.pop_front();
            check_field("upper_first_index", got.upper_first, want.upper_first);
            check_field("upper_second_index", got.upper_second, want.upper_second);
            check_field("lower_first_index", got.lower_first, want.lower_first);
            check_field("lower_second_index", got.lower_second, want.lower_second);
            check_field("run_last", 4'(got.run_last), 4'(want.run_last));
            check_field("line_end", 4'(got.line_end), 4'(want.line_end));
        endtask
    endclass

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic               cfg_mono_enable = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_aux_byte      = '0;
    logic [BYTE_W-1:0]  s_main_byte     = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [INDEX_W-1:0] m_upper_first_index;
    logic [INDEX_W-1:0] m_upper_second_index;
    logic [INDEX_W-1:0] m_lower_first_index;
    logic [INDEX_W-1:0] m_lower_second_index;
    logic               m_run_last;
    logic               m_line_end;

    dot_word_scoreboard sb = new(LINE_COLUMNS);
    bit no_idle     = 1'b0;
    int ready_wait  = 0;
    int idle_cycles = 0;

    double_lores_dot_serializer_unit #(
        .COLUMNS (LINE_COLUMNS)
    ) u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_mono_enable      (cfg_mono_enable),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_aux_byte           (s_aux_byte),
        .s_main_byte          (s_main_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_upper_first_index  (m_upper_first_index),
        .m_upper_second_index (m_upper_second_index),
        .m_lower_first_index  (m_lower_first_index),
        .m_lower_second_index (m_lower_second_index),
        .m_run_last           (m_run_last),
        .m_line_end           (m_line_end)
    );

    always #10 aclk = ~aclk;

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 4));
    endfunction

    // result side: check each beat, then stall for a random number of cycles
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            sb.check_word({m_upper_first_index, m_upper_second_index,
                           m_lower_first_index, m_lower_second_index,
                           m_run_last, m_line_end});
            ready_wait = draw_wait();
        end else if (ready_wait > 0) begin
            ready_wait--;
        end
        m_ready <= (ready_wait == 0);
    end

    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready === 1'b1)
                || (m_valid === 1'b1 && m_ready)
                || (cfg_valid && cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // valid stays up across back-to-back beats, so it is only lowered before a gap
    task automatic send_column(input logic [7:0] aux, input logic [7:0] mainb);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_aux_byte  <= aux;
        s_main_byte <= mainb;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_column(aux, mainb);
    endtask

    task automatic set_mode(input bit mono);
        s_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid       <= 1'b1;
        cfg_mono_enable <= mono;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.mono = mono;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_columns(input int count);
        int         k;
        int         kind;
        logic [7:0] aux;
        logic [7:0] mainb;
        for (k = 0; k < count; k++) begin
            if (k % 12 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 7);
            aux   = (kind == 0) ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
                                : 8'($urandom_range(0, 255));
            mainb = (kind == 1) ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
                                : 8'($urandom_range(0, 255));
            send_column(aux, mainb);
        end
    endtask

    initial begin
        int i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // color mode from reset: line start word, extremes, every nibble
        send_column(8'h00, 8'h00);
        send_column(8'hff, 8'hff);
        send_column(8'h0f, 8'hf0);
        send_column(8'hf0, 8'h0f);
        for (i = 0; i < 16; i++)
            send_column({i[3:0], 4'(15 - i)}, {4'(15 - i), i[3:0]});

        // mode flips land mid-line, so leftover dots cross over
        set_mode(1'b1);
        random_columns(50);
        set_mode(1'b0);
        random_columns(50);
        set_mode(1'b1);
        random_columns(30);
        set_mode(1'b0);
        random_columns(30);

        s_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dlds_pkg.sv
hdl/dlds_front.sv
hdl/dlds_queue.sv
hdl/dlds_back.sv
hdl/double_lores_dot_serializer_unit.sv
hdl/dlds_checker.sv
sim/tb_double_lores_dot_serializer_unit.sv
